/* rtl/sfla_pkg.sv */
// Package for the segregated free-list allocator: shared types, codes and constants.
// Depends on nothing; every other file of the block imports it.
package sfla_pkg;

    // Link words and block addresses are 16 bits wide; the link store covers all of them.
    localparam int ADDR_W     = 16;
    localparam int SIZE_W     = 12;
    localparam int STOP_W     = 17;
    localparam int STACK_GAP  = 51;

    // Request actions.
    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    // Response status codes.
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_EXHAUSTED = 2'd1;
    localparam logic [1:0] ST_TOO_LARGE = 2'd2;
    localparam logic [1:0] ST_INVALID   = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FHEAD,
        S_AHEAD,
        S_LINK,
        S_SUM,
        S_GAP,
        S_CMP,
        S_CARVE,
        S_RESULT
    } t_state;

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } t_alu_op;

    // Command to the link-word memory.
    typedef struct packed {
        logic              rd_en;
        logic              wr_en;
        logic [ADDR_W-1:0] addr;
        logic [ADDR_W-1:0] wr_data;
    } t_link_cmd;

endpackage

/* rtl/sfla_if.sv */
// Valid/ready channel interfaces of the allocator: request channel and response channel.
// Depends on sfla_pkg for the field widths.
interface sfla_req_if
    import sfla_pkg::*;
;
    logic              valid;
    logic              ready;
    logic              action;
    logic [SIZE_W-1:0] block_size;
    logic [ADDR_W-1:0] block_address;
    logic [STOP_W-1:0] stack_top;

    modport source (output valid, action, block_size, block_address, stack_top, input ready);
    modport sink   (input valid, action, block_size, block_address, stack_top, output ready);
endinterface

interface sfla_rsp_if
    import sfla_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] result_address;
    logic [1:0]        status;

    modport source (output valid, result_address, status, input ready);
    modport sink   (input valid, result_address, status, output ready);
endinterface

/* rtl/sfla_alu.sv */
// Shared adder/subtractor of the allocator, reused for every heap-bound step.
// Depends on sfla_pkg for the operation codes.
module sfla_alu
    import sfla_pkg::*;
#(
    parameter int W = 18
) (
    input  t_alu_op      i_op,
    input  logic [W-1:0] i_a,
    input  logic [W-1:0] i_b,
    output logic [W-1:0] o_res,
    output logic         o_borrow
);

    logic [W:0] w_full;

    always_comb begin
        unique case (i_op)
            ALU_ADD: w_full = {1'b0, i_a} + {1'b0, i_b};
            ALU_SUB: w_full = {1'b0, i_a} - {1'b0, i_b};
            default: w_full = '0;
        endcase
    end

    // On a subtraction the top bit is the borrow, set when i_b exceeds i_a.
    assign o_res    = w_full[W-1:0];
    assign o_borrow = w_full[W] & (i_op == ALU_SUB);

endmodule

/* rtl/sfla_heads.sv */
// Free-list head store: one head address per size class, registered read, valid bit per class.
// Depends on sfla_pkg for the address width.
module sfla_heads
    import sfla_pkg::*;
#(
    parameter int  SIZE_CLASSES = 16,
    localparam int CLS_W = (SIZE_CLASSES > 1) ? $clog2(SIZE_CLASSES) : 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_rd_en,
    input  logic [CLS_W-1:0]  i_rd_idx,
    input  logic              i_wr_en,
    input  logic [CLS_W-1:0]  i_wr_idx,
    input  logic [ADDR_W-1:0] i_wr_data,
    output logic [ADDR_W-1:0] o_head
);

    logic [ADDR_W-1:0]       r_mem [SIZE_CLASSES];
    logic [SIZE_CLASSES-1:0] r_valid;
    logic [ADDR_W-1:0]       r_rd_data;
    logic                    r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_idx] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_idx];
        end
    end

    // A class never written since reset reads as an empty list.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_idx] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_valid <= r_valid[i_rd_idx];
            end
        end
    end

    assign o_head = r_rd_valid ? r_rd_data : '0;

endmodule

/* rtl/sfla_link_ram.sv */
// Link-word memory of the allocator: one link word per block address, single port.
// Depends on sfla_pkg for the command structure.
module sfla_link_ram
    import sfla_pkg::*;
(
    input  logic              i_clk,
    input  t_link_cmd         i_cmd,
    output logic [ADDR_W-1:0] o_rd_data
);

    localparam int DEPTH = 1 << ADDR_W;

    logic [ADDR_W-1:0] r_mem [DEPTH];
    logic [ADDR_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[i_cmd.addr] <= i_cmd.wr_data;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[i_cmd.addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* rtl/segregated_free_list_allocator_unit.sv */
// Top level of the segregated free-list allocator: sequencer, heap-bottom register, result stage.
// Depends on sfla_pkg, sfla_if, sfla_alu, sfla_heads and sfla_link_ram.
//
// The unit takes one request word at a time on i_req and returns exactly one response word on
// o_rsp. A free of a block of 1 to SIZE_CLASSES words pushes it onto the list for its size,
// writing the old head into the block's link word; larger frees are ignored with status 2.
// An allocation pops the list for its size when it is not empty, and otherwise carves the
// block just below the heap bottom, provided its lowest word lies at least 50 words above
// stack_top, else it answers status 1 with address 0. Size zero answers status 3. A free
// goes through a synchronous read of the head store, and a pop through one of the head store
// and then one of the link memory. A carve or an exhaustion uses the single adder/subtractor,
// which the carve path uses four times in turn (stack top plus size, plus the gap, compare,
// then subtract), after a head read when the size has a list of its own.
// i_req.ready is high only while the sequencer is idle. The response sits in its own output
// register, so a new request is taken while the previous response still waits to be
// collected; the new response is then held in the sequencer, which stays busy, until the
// older one has gone. A link word that was never written must not be popped; its contents
// are then undefined. No clearing pass is needed after reset.
module segregated_free_list_allocator_unit
    import sfla_pkg::*;
#(
    parameter int HEAP_WORDS   = 65536,
    parameter int SIZE_CLASSES = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sfla_req_if.sink   i_req,
    sfla_rsp_if.source o_rsp
);

    // Heap bottom must hold HEAP_WORDS itself; the adder must also hold stack top + size + gap.
    localparam int HB_W  = $clog2(HEAP_WORDS + 1);
    localparam int AW    = (HB_W > STOP_W + 1) ? HB_W : STOP_W + 1;
    localparam int CLS_W = (SIZE_CLASSES > 1) ? $clog2(SIZE_CLASSES) : 1;

    t_state            r_state, n_state;
    logic [SIZE_W-1:0] r_size, n_size;
    logic [ADDR_W-1:0] r_addr, n_addr;
    logic [STOP_W-1:0] r_stop, n_stop;
    logic [CLS_W-1:0]  r_cls, n_cls;
    logic [ADDR_W-1:0] r_blk, n_blk;
    logic [AW-1:0]     r_acc, n_acc;
    logic [HB_W-1:0]   r_heap_bottom, n_heap_bottom;
    logic [ADDR_W-1:0] r_res_addr, n_res_addr;
    logic [1:0]        r_res_status, n_res_status;
    logic              r_out_valid, n_out_valid;
    logic [ADDR_W-1:0] r_out_addr, n_out_addr;
    logic [1:0]        r_out_status, n_out_status;

    // Shared arithmetic unit.
    t_alu_op       w_alu_op;
    logic [AW-1:0] w_alu_a;
    logic [AW-1:0] w_alu_b;
    logic [AW-1:0] w_alu_res;
    logic          w_alu_borrow;

    // Head store and link memory controls.
    logic              w_head_rd_en;
    logic [CLS_W-1:0]  w_head_rd_idx;
    logic              w_head_wr_en;
    logic [ADDR_W-1:0] w_head_wr_data;
    logic [ADDR_W-1:0] w_head;
    t_link_cmd         w_link_cmd;
    logic [ADDR_W-1:0] w_link_data;

    logic             w_small_in;
    logic [CLS_W-1:0] w_cls_in;

    // A size of 1..SIZE_CLASSES words has a list of its own; the class is size minus one.
    assign w_small_in = (i_req.block_size <= SIZE_W'(SIZE_CLASSES));
    assign w_cls_in   = CLS_W'(i_req.block_size - SIZE_W'(1));

    sfla_alu #(
        .W (AW)
    ) u_alu (
        .i_op     (w_alu_op),
        .i_a      (w_alu_a),
        .i_b      (w_alu_b),
        .o_res    (w_alu_res),
        .o_borrow (w_alu_borrow)
    );

    sfla_heads #(
        .SIZE_CLASSES (SIZE_CLASSES)
    ) u_heads (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (w_head_rd_en),
        .i_rd_idx  (w_head_rd_idx),
        .i_wr_en   (w_head_wr_en),
        .i_wr_idx  (r_cls),
        .i_wr_data (w_head_wr_data),
        .o_head    (w_head)
    );

    sfla_link_ram u_link (
        .i_clk     (i_clk),
        .i_cmd     (w_link_cmd),
        .o_rd_data (w_link_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_heap_bottom <= HB_W'(HEAP_WORDS);
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_heap_bottom <= n_heap_bottom;
            r_out_valid   <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_size       <= n_size;
        r_addr       <= n_addr;
        r_stop       <= n_stop;
        r_cls        <= n_cls;
        r_blk        <= n_blk;
        r_acc        <= n_acc;
        r_res_addr   <= n_res_addr;
        r_res_status <= n_res_status;
        r_out_addr   <= n_out_addr;
        r_out_status <= n_out_status;
    end

    always_comb begin
        n_state       = r_state;
        n_size        = r_size;
        n_addr        = r_addr;
        n_stop        = r_stop;
        n_cls         = r_cls;
        n_blk         = r_blk;
        n_acc         = r_acc;
        n_heap_bottom = r_heap_bottom;
        n_res_addr    = r_res_addr;
        n_res_status  = r_res_status;
        n_out_valid   = r_out_valid;
        n_out_addr    = r_out_addr;
        n_out_status  = r_out_status;

        w_alu_op       = ALU_ADD;
        w_alu_a        = '0;
        w_alu_b        = '0;
        w_head_rd_en   = 1'b0;
        w_head_rd_idx  = w_cls_in;
        w_head_wr_en   = 1'b0;
        w_head_wr_data = r_addr;
        w_link_cmd     = '0;

        // The waiting response leaves as soon as the consumer takes it.
        if (r_out_valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_size = i_req.block_size;
                    n_addr = i_req.block_address;
                    n_stop = i_req.stack_top;
                    n_cls  = w_cls_in;
                    if (i_req.block_size == '0) begin
                        n_res_addr   = '0;
                        n_res_status = ST_INVALID;
                        n_state      = S_RESULT;
                    end else if (i_req.action == ACT_FREE) begin
                        if (w_small_in) begin
                            w_head_rd_en = 1'b1;
                            n_state      = S_FHEAD;
                        end else begin
                            n_res_addr   = '0;
                            n_res_status = ST_TOO_LARGE;
                            n_state      = S_RESULT;
                        end
                    end else if (w_small_in) begin
                        w_head_rd_en = 1'b1;
                        n_state      = S_AHEAD;
                    end else begin
                        n_state = S_SUM;
                    end
                end
            end
            S_FHEAD: begin
                // Push: the old head becomes the block's link, the block becomes the head.
                w_link_cmd.wr_en    = 1'b1;
                w_link_cmd.addr     = r_addr;
                w_link_cmd.wr_data  = w_head;
                w_head_wr_en        = 1'b1;
                w_head_wr_data      = r_addr;
                n_res_addr          = '0;
                n_res_status        = ST_OK;
                n_state             = S_RESULT;
            end
            S_AHEAD: begin
                if (w_head == '0) begin
                    n_state = S_SUM;
                end else begin
                    w_link_cmd.rd_en = 1'b1;
                    w_link_cmd.addr  = w_head;
                    n_blk            = w_head;
                    n_state          = S_LINK;
                end
            end
            S_LINK: begin
                w_head_wr_en   = 1'b1;
                w_head_wr_data = w_link_data;
                n_res_addr     = r_blk;
                n_res_status   = ST_OK;
                n_state        = S_RESULT;
            end
            S_SUM: begin
                w_alu_op = ALU_ADD;
                w_alu_a  = AW'(r_stop);
                w_alu_b  = AW'(r_size);
                n_acc    = w_alu_res;
                n_state  = S_GAP;
            end
            S_GAP: begin
                // Stack top + gap + size - 1 is the lowest heap bottom from which the block may be carved.
                w_alu_op = ALU_ADD;
                w_alu_a  = r_acc;
                w_alu_b  = AW'(STACK_GAP - 1);
                n_acc    = w_alu_res;
                n_state  = S_CMP;
            end
            S_CMP: begin
                w_alu_op = ALU_SUB;
                w_alu_a  = AW'(r_heap_bottom);
                w_alu_b  = r_acc;
                if (w_alu_borrow) begin
                    n_res_addr   = '0;
                    n_res_status = ST_EXHAUSTED;
                    n_state      = S_RESULT;
                end else begin
                    n_state = S_CARVE;
                end
            end
            S_CARVE: begin
                w_alu_op      = ALU_SUB;
                w_alu_a       = AW'(r_heap_bottom);
                w_alu_b       = AW'(r_size);
                n_heap_bottom = HB_W'(w_alu_res);
                n_res_addr    = w_alu_res[ADDR_W-1:0];
                n_res_status  = ST_OK;
                n_state       = S_RESULT;
            end
            S_RESULT: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid  = 1'b1;
                    n_out_addr   = r_res_addr;
                    n_out_status = r_res_status;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign i_req.ready          = (r_state == S_IDLE);
    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.result_address = r_out_addr;
    assign o_rsp.status         = r_out_status;

    // The heap bottom only ever moves downward, and only by a carve.
    a_carve_lowers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CARVE) |=> (r_heap_bottom < $past(r_heap_bottom)))
        else $error("heap bottom did not fall on a carve");

    a_bottom_only_on_carve: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && r_state != S_CARVE) |=> $stable(r_heap_bottom))
        else $error("heap bottom changed outside a carve");

    a_bottom_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_heap_bottom <= HB_W'(HEAP_WORDS))
        else $error("heap bottom above the top of the heap");

    a_fail_no_address: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.status != ST_OK) |-> (o_rsp.result_address == '0))
        else $error("failed request returned an address");

endmodule

/* sim/segregated_free_list_allocator_unit_tb.sv */
// Self-checking testbench for segregated_free_list_allocator_unit: directed and random requests.
// Depends on sfla_pkg, the sfla_req_if and sfla_rsp_if interfaces, and the allocator RTL.
// A behavioural model of the heap predicts every response; responses are checked in order.
`timescale 1ns / 1ps

module segregated_free_list_allocator_unit_tb
    import sfla_pkg::*;
;

    localparam int HEAP_WORDS        = 65536;
    localparam int SIZE_CLASSES      = 16;
    localparam int HALF_PERIOD       = 6;
    localparam int RESET_CYCLES      = 5;
    localparam int RANDOM_REQUESTS   = 1730;
    localparam int STACK_TOP_MAX     = (1 << STOP_W) - 1;
    // The receiver stops collecting for a long while once this many responses have been seen.
    localparam int LONG_STALL_AT     = 200;
    localparam int LONG_STALL_CYCLES = 400;
    localparam int DRAIN_EVERY       = 150;
    localparam int SETTLE_CYCLES     = 16;
    // The limit allows several times the worst case per request (sender gap, busy sequencer,
    // receiver stall) for every request.
    localparam int CYCLE_LIMIT       = 400000;

    typedef struct packed {
        logic              action;
        logic [SIZE_W-1:0] block_size;
        logic [ADDR_W-1:0] block_address;
        logic [STOP_W-1:0] stack_top;
    } t_request;

    // A request waiting to be sent; drain_first makes the sender wait until every
    // outstanding response has been collected before offering it.
    typedef struct {
        t_request req;
        bit       drain_first;
    } t_queued_request;

    typedef struct packed {
        logic [ADDR_W-1:0] result_address;
        logic [1:0]        status;
    } t_response;

    typedef struct {
        logic [ADDR_W-1:0] addr;
        logic [SIZE_W-1:0] size;
    } t_live_block;

    logic i_clk;
    logic i_rst_n;

    sfla_req_if req_if ();
    sfla_rsp_if rsp_if ();

    segregated_free_list_allocator_unit #(
        .HEAP_WORDS   (HEAP_WORDS),
        .SIZE_CLASSES (SIZE_CLASSES)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if.sink),
        .o_rsp   (rsp_if.source)
    );

    // Shadow copy of the heap: one list head per size class, the downward-growing floor of
    // the heap, and the link words written so far. A link word that is absent has never
    // been written.
    logic [ADDR_W-1:0] list_head [SIZE_CLASSES];
    int                heap_floor;
    logic [ADDR_W-1:0] link_word [bit [ADDR_W-1:0]];

    // Blocks handed out and not yet given back; the stimulus frees them with their own size.
    t_live_block       live_blocks [$];

    t_queued_request   request_backlog [$];
    t_response         pending_responses [$];

    int requests_queued;
    int requests_offered;
    int requests_taken;
    int responses_seen;
    int responses_handled;
    int failures;
    int cycle_count;

    // Sender and receiver state.
    t_queued_request   tx_word;
    bit                tx_loaded;
    bit                tx_burst;
    int                tx_gap;
    logic              tx_valid_next;
    bit                rx_burst;
    int                rx_hold;
    t_response         wanted;

    always #(HALF_PERIOD) i_clk = ~i_clk;

    // Works out the response to one request and moves the shadow heap on accordingly.
    function automatic t_response heap_response(input t_request rq);
        t_response         rsp;
        int                cls;
        logic [ADDR_W-1:0] blk;
        rsp = '0;
        cls = int'(rq.block_size) - 1;
        if (rq.block_size == '0) begin
            rsp.status = ST_INVALID;
        end else if (rq.action == ACT_FREE) begin
            if (cls < SIZE_CLASSES) begin
                // Push: the old head goes into the block's link word. Freeing address zero
                // leaves the list reading as empty.
                link_word[rq.block_address] = list_head[cls];
                list_head[cls] = rq.block_address;
                rsp.status = ST_OK;
            end else begin
                rsp.status = ST_TOO_LARGE;
            end
        end else if (cls < SIZE_CLASSES && list_head[cls] != '0) begin
            // Pop: no stack check is made when the list can serve the request.
            blk = list_head[cls];
            list_head[cls] = link_word.exists(blk) ? link_word[blk] : '0;
            rsp.result_address = blk;
            rsp.status = ST_OK;
            live_blocks.push_back('{addr: blk, size: rq.block_size});
        end else if (int'(rq.stack_top) + STACK_GAP + cls > heap_floor) begin
            rsp.status = ST_EXHAUSTED;
        end else begin
            heap_floor = heap_floor - int'(rq.block_size);
            rsp.result_address = heap_floor[ADDR_W-1:0];
            rsp.status = ST_OK;
            live_blocks.push_back('{addr: heap_floor[ADDR_W-1:0], size: rq.block_size});
        end
        return rsp;
    endfunction

    task automatic queue_request(input logic action, input int size, input int addr,
                                 input int stack_top, input bit drain_first);
        t_queued_request q;
        q.req.action        = action;
        q.req.block_size    = SIZE_W'(size);
        q.req.block_address = ADDR_W'(addr);
        q.req.stack_top     = STOP_W'(stack_top);
        q.drain_first       = drain_first;
        request_backlog.push_back(q);
        requests_queued++;
    endtask

    // An allocation placed right at the stack guard: an offset of zero fits exactly and an
    // offset of one is a word short. The shadow heap must be up to date, so every request
    // queued so far has to be taken first.
    task automatic queue_guard_alloc(input int size, input int offset);
        int stack_top;
        wait (requests_taken == requests_queued);
        stack_top = heap_floor - STACK_GAP - (size - 1) + offset;
        if (stack_top < 0) begin
            stack_top = 0;
        end
        if (stack_top > STACK_TOP_MAX) begin
            stack_top = STACK_TOP_MAX;
        end
        queue_request(ACT_ALLOC, size, 0, stack_top, 1'b1);
    endtask

    // Sender: inputs change on the falling edge only. An offered word stays put until the
    // monitor has counted it as taken; then the next one may follow at once or after a gap.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else if (!(req_if.valid && requests_taken != requests_offered)) begin
            tx_valid_next = 1'b0;
            if (!tx_loaded && request_backlog.size() != 0) begin
                tx_word   = request_backlog.pop_front();
                tx_loaded = 1'b1;
                if ($urandom_range(0, 29) == 0) begin
                    tx_burst = !tx_burst;
                end
                tx_gap = tx_burst ? 0 : $urandom_range(0, 14);
            end
            if (tx_loaded) begin
                if (tx_gap != 0) begin
                    tx_gap--;
                end else if (!tx_word.drain_first || pending_responses.size() == 0) begin
                    req_if.action        <= tx_word.req.action;
                    req_if.block_size    <= tx_word.req.block_size;
                    req_if.block_address <= tx_word.req.block_address;
                    req_if.stack_top     <= tx_word.req.stack_top;
                    tx_valid_next = 1'b1;
                    tx_loaded     = 1'b0;
                    requests_offered++;
                end
            end
            req_if.valid <= tx_valid_next;
        end
    end

    // Receiver: after each collected word it holds ready low for a drawn number of cycles,
    // and once for a long stretch so that the unit backs up and refuses requests.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
        end else begin
            if (responses_seen != responses_handled) begin
                responses_handled = responses_seen;
                if ($urandom_range(0, 29) == 0) begin
                    rx_burst = !rx_burst;
                end
                rx_hold = rx_burst ? 0 : $urandom_range(0, 14);
                if (responses_seen == LONG_STALL_AT) begin
                    rx_hold = LONG_STALL_CYCLES;
                end
            end
            if (rx_hold != 0) begin
                rx_hold--;
                rsp_if.ready <= 1'b0;
            end else begin
                rsp_if.ready <= 1'b1;
            end
        end
    end

    // Monitor: both handshakes are sampled on the rising edge. The response is checked
    // before the request of the same edge is predicted, as it belongs to an older request.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (rsp_if.valid && rsp_if.ready) begin
                responses_seen++;
                if (pending_responses.size() == 0) begin
                    $error("unexpected response: result_address %h, status %0d",
                           rsp_if.result_address, rsp_if.status);
                    failures++;
                end else begin
                    wanted = pending_responses.pop_front();
                    if (rsp_if.result_address !== wanted.result_address) begin
                        $error("result_address: expected %h, actual %h",
                               wanted.result_address, rsp_if.result_address);
                        failures++;
                    end
                    if (rsp_if.status !== wanted.status) begin
                        $error("status: expected %0d, actual %0d",
                               wanted.status, rsp_if.status);
                        failures++;
                    end
                end
            end
            if (req_if.valid && req_if.ready) begin
                requests_taken++;
                pending_responses.push_back(heap_response(t_request'{
                    req_if.action, req_if.block_size, req_if.block_address,
                    req_if.stack_top}));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        t_live_block blk;
        int          pick;
        int          idx;
        int          size;
        i_clk                = 1'b0;
        i_rst_n              = 1'b0;
        req_if.valid         = 1'b0;
        req_if.action        = ACT_ALLOC;
        req_if.block_size    = '0;
        req_if.block_address = '0;
        req_if.stack_top     = '0;
        rsp_if.ready         = 1'b0;
        heap_floor           = HEAP_WORDS;
        foreach (list_head[i]) begin
            list_head[i] = '0;
        end

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part. Size zero is rejected for both actions, and frees above the
        // largest class are ignored.
        queue_request(ACT_ALLOC, 0, 0, 0, 1'b0);
        queue_request(ACT_FREE, 0, 16'hFFFF, STACK_TOP_MAX, 1'b0);
        queue_request(ACT_FREE, SIZE_CLASSES + 1, 16'h1234, 0, 1'b0);
        queue_request(ACT_FREE, 4095, 16'hFFFF, 0, 1'b0);
        // Carves from an untouched heap, smallest and largest class.
        queue_request(ACT_ALLOC, 1, 0, 0, 1'b0);
        queue_request(ACT_ALLOC, SIZE_CLASSES, 16'hFFFF, 0, 1'b0);
        // Two pushes onto one list come back in reverse order, then the empty list carves.
        queue_request(ACT_FREE, SIZE_CLASSES, 16'hFFFF, 0, 1'b0);
        queue_request(ACT_FREE, SIZE_CLASSES, 16'h8000, 0, 1'b0);
        queue_request(ACT_ALLOC, SIZE_CLASSES, 0, 0, 1'b0);
        queue_request(ACT_ALLOC, SIZE_CLASSES, 0, 0, 1'b0);
        queue_request(ACT_ALLOC, SIZE_CLASSES, 0, 0, 1'b0);
        // Freeing the null address hides the block pushed before it.
        queue_request(ACT_FREE, 3, 16'h0100, 0, 1'b0);
        queue_request(ACT_FREE, 3, 0, 0, 1'b0);
        queue_request(ACT_ALLOC, 3, 0, 0, 1'b0);
        // A large allocation always carves, even with the largest size.
        queue_request(ACT_ALLOC, 4095, 0, 0, 1'b0);
        // Exhaustion with the stack top at its maximum and at the top of the heap.
        queue_request(ACT_ALLOC, 1, 0, STACK_TOP_MAX, 1'b0);
        queue_request(ACT_ALLOC, 20, 0, HEAP_WORDS, 1'b0);
        // A pop succeeds whatever the stack top says.
        queue_request(ACT_FREE, 1, 1, 0, 1'b0);
        queue_request(ACT_ALLOC, 1, 0, STACK_TOP_MAX, 1'b1);
        // Exactly at the guard, then one word past it, then exactly at it with a large size.
        queue_guard_alloc(7, 0);
        queue_guard_alloc(7, 1);
        queue_guard_alloc(SIZE_CLASSES + 3, 0);

        // Random part: mostly allocations and frees of blocks that were handed out, with
        // noise in between.
        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                queue_request(ACT_ALLOC, $urandom_range(1, SIZE_CLASSES), $urandom_range(0, 65535),
                              $urandom_range(0, 1023), (n % DRAIN_EVERY) == 0);
            end else if (pick < 68) begin
                if (live_blocks.size() != 0) begin
                    idx = $urandom_range(0, live_blocks.size() - 1);
                    blk = live_blocks[idx];
                    live_blocks.delete(idx);
                    queue_request(ACT_FREE, blk.size, blk.addr, $urandom_range(0, STACK_TOP_MAX),
                                  1'b0);
                end else begin
                    queue_request(ACT_FREE, $urandom_range(1, SIZE_CLASSES),
                                  $urandom_range(0, 65535), $urandom_range(0, STACK_TOP_MAX), 1'b0);
                end
            end else if (pick < 73) begin
                queue_request(ACT_FREE, $urandom_range(1, 4095), $urandom_range(0, 65535),
                              $urandom_range(0, STACK_TOP_MAX), 1'b0);
            end else if (pick < 79) begin
                // Large allocations: mostly modest, a few up to the largest size.
                size = ($urandom_range(0, 15) == 0) ? $urandom_range(SIZE_CLASSES + 1, 4095)
                                                    : $urandom_range(SIZE_CLASSES + 1, 64);
                queue_request(ACT_ALLOC, size, $urandom_range(0, 65535),
                              $urandom_range(0, 1023), 1'b0);
            end else if (pick < 84) begin
                queue_request(1'($urandom_range(0, 1)), 0, $urandom_range(0, 65535),
                              $urandom_range(0, STACK_TOP_MAX), 1'b0);
            end else if (pick < 94) begin
                queue_request(ACT_ALLOC, $urandom_range(1, 2 * SIZE_CLASSES),
                              $urandom_range(0, 65535), $urandom_range(0, STACK_TOP_MAX), 1'b0);
            end else begin
                queue_guard_alloc($urandom_range(1, 2 * SIZE_CLASSES), $urandom_range(0, 2) - 1);
            end
        end

        // Every request must have been taken and answered; then a short quiet spell
        // catches any stray response.
        wait (requests_taken == requests_queued && pending_responses.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (failures == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

/* segregated_free_list_allocator_unit.f */
rtl/sfla_pkg.sv
rtl/sfla_if.sv
rtl/sfla_alu.sv
rtl/sfla_heads.sv
rtl/sfla_link_ram.sv
rtl/segregated_free_list_allocator_unit.sv
sim/segregated_free_list_allocator_unit_tb.sv
